// File: hw/rtl/bgd_pkg.sv
`default_nettype none
package bgd_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW = 16;
  localparam int unsigned InDataW = 40;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned AddrW = 3;

  localparam logic [CfgW-1:0] WindowReset = 16'd300;
  localparam logic [CfgW-1:0] HoldReset = 16'd600;

  // register index, taken from paddr[2]
  localparam logic RegWindow = 1'b0;
  localparam logic RegHold = 1'b1;

  typedef struct packed {
    logic [CfgW-1:0] window;
    logic [CfgW-1:0] hold;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] time_now;
    logic button_level;
  } sample_t;

  typedef struct packed {
    logic hold_release_event;
    logic hold_start_event;
    logic double_click_event;
    logic click_event;
    logic release_event;
    logic press_event;
  } events_t;

endpackage
`default_nettype wire

// File: hw/rtl/bgd_cfg_regs.sv
`default_nettype none
module bgd_cfg_regs (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [bgd_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  output bgd_pkg::cfg_t cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window <= bgd_pkg::WindowReset;
      cfg.hold <= bgd_pkg::HoldReset;
    end else if (wr_en) begin
      unique case (paddr[2])
        bgd_pkg::RegWindow: cfg.window <= pwdata[bgd_pkg::CfgW-1:0];
        bgd_pkg::RegHold: cfg.hold <= pwdata[bgd_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bgd_pkg::RegWindow: prdata = {16'd0, cfg.window};
      bgd_pkg::RegHold: prdata = {16'd0, cfg.hold};
      default: prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/bgd_in_stage.sv
`default_nettype none
module bgd_in_stage (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic s_tready,
  input  wire logic [bgd_pkg::InDataW-1:0] s_tdata,
  input  wire logic advance,
  output logic item_valid,
  output bgd_pkg::sample_t item
);

  logic take;

  assign s_tready = !item_valid || advance;
  assign take = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.button_level <= s_tdata[0];
      item.time_now <= s_tdata[bgd_pkg::TimeW:1];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/bgd_eval.sv
`default_nettype none
module bgd_eval (
  input  wire logic clk,
  input  wire logic rst,
  input  wire bgd_pkg::cfg_t cfg,
  input  wire logic item_valid,
  input  wire bgd_pkg::sample_t item,
  output logic advance,
  output logic m_tvalid,
  input  wire logic m_tready,
  output logic [bgd_pkg::OutDataW-1:0] m_tdata
);

  logic last_level;
  logic holding;
  logic awaiting_second;
  logic [bgd_pkg::TimeW-1:0] press_time;
  logic [bgd_pkg::TimeW-1:0] release_time;
  bgd_pkg::events_t result;

  logic last_level_next;
  logic holding_next;
  logic awaiting_next;
  logic [bgd_pkg::TimeW-1:0] press_time_next;
  logic [bgd_pkg::TimeW-1:0] release_time_next;
  bgd_pkg::events_t ev;

  logic [bgd_pkg::TimeW-1:0] since_release;
  logic [bgd_pkg::TimeW-1:0] since_press;
  logic expired;
  logic hold_reached;
  logic aw_live;

  assign advance = item_valid && (!m_tvalid || m_tready);

  assign since_release = item.time_now - release_time;
  assign since_press = item.time_now - press_time;
  assign expired = since_release > {16'd0, cfg.window};
  assign hold_reached = since_press >= {16'd0, cfg.hold};
  assign aw_live = awaiting_second && !expired;

  always_comb begin
    ev = '0;
    last_level_next = item.button_level;
    holding_next = holding;
    awaiting_next = aw_live;
    press_time_next = press_time;
    release_time_next = release_time;
    ev.click_event = awaiting_second && expired;
    if (item.button_level != last_level) begin
      if (item.button_level) begin
        press_time_next = item.time_now;
        ev.press_event = 1'b1;
      end else begin
        ev.release_event = 1'b1;
        if (holding) begin
          holding_next = 1'b0;
          ev.hold_release_event = 1'b1;
          awaiting_next = 1'b0;
        end else if (aw_live) begin
          ev.double_click_event = 1'b1;
          awaiting_next = 1'b0;
        end else begin
          awaiting_next = 1'b1;
          release_time_next = item.time_now;
        end
      end
    end else if (last_level && !holding && hold_reached) begin
      holding_next = 1'b1;
      ev.hold_start_event = 1'b1;
      awaiting_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level <= 1'b0;
      holding <= 1'b0;
      awaiting_second <= 1'b0;
      press_time <= '0;
      release_time <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        last_level <= last_level_next;
        holding <= holding_next;
        awaiting_second <= awaiting_next;
        press_time <= press_time_next;
        release_time <= release_time_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= ev;
    end
  end

  assign m_tdata = {2'b00, result};

endmodule
`default_nettype wire

// File: hw/rtl/button_gesture_detector.sv
// button gesture detector
// s_* channel: one request per button sample, tdata = {time_now, button_level}
// in bits [32:1] and [0]; time_now is a free-running ms count that wraps
// m_* channel: one result per sample, six event pulses in tdata bits [5:0]:
// press, release, click, double click, hold start, hold release
// apb port: register 0 at 0x0 is the double-click window (reset 300 ms),
// register 1 at 0x4 is the hold threshold (reset 600 ms); write only while idle
// latency: two cycles from an accepted sample to its result on m_*, one cycle
// in the input register and one in the result register
// throughput: one sample per cycle; the state update for a sample happens in
// the same cycle that its result is registered, so samples may be back to back
// reset clears the state (level released, no hold, no pending click, both
// time stamps zero), restores the register defaults and empties both stages
// when m_tready is low the result holds, the input register still takes one
// more sample, and s_tready then drops until the result is taken
`default_nettype none
module button_gesture_detector (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic s_tready,
  input  wire logic [bgd_pkg::InDataW-1:0] s_tdata, // button_level, time_now
  output logic m_tvalid,
  input  wire logic m_tready,
  // press, release, click, double_click, hold_start, hold_release events
  output logic [bgd_pkg::OutDataW-1:0] m_tdata,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [bgd_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  bgd_pkg::cfg_t cfg;
  bgd_pkg::sample_t item;
  logic item_valid;
  logic advance;

  bgd_cfg_regs u_cfg (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .cfg(cfg)
  );

  bgd_in_stage u_in (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .advance(advance),
    .item_valid(item_valid),
    .item(item)
  );

  bgd_eval u_eval (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .item_valid(item_valid),
    .item(item),
    .advance(advance),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

endmodule
`default_nettype wire

// File: hw/rtl/bgd_checker.sv
`default_nettype none
module bgd_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic m_tvalid,
  input wire logic m_tready,
  input wire logic [bgd_pkg::OutDataW-1:0] m_tdata
);

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed under stall");

  // press and release never in one sample
  a_edge_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("press and release together");

  // double click and hold release only come with a release
  a_rel_needed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[3] || m_tdata[5]) |-> m_tdata[1])
    else $error("double click or hold release without release");

  // hold start only in a sample without an edge
  a_hold_no_edge: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4] |-> !m_tdata[0] && !m_tdata[1])
    else $error("hold start with an edge");

endmodule

bind button_gesture_detector bgd_checker u_bgd_checker (
  .clk(clk),
  .rst(rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata)
);
`default_nettype wire
